// ===== sv/dsv_pkg.sv =====
// Package for the date string validator: field codes, character constants,
// the parser snapshot and result structs. No dependencies.
package dsv_pkg;

  localparam int CHAR_W  = 8;
  localparam int FLD_W   = 2;
  localparam int CNT_W   = 3;
  localparam int VAL_W   = 7;
  localparam int YDIG_W  = 16;
  localparam int DAY_W   = 5;
  localparam int MONTH_W = 4;
  localparam int YEAR_W  = 14;
  localparam int DIGIT_W = 4;

  localparam logic [FLD_W-1:0] FLD_DAY   = 2'd0;
  localparam logic [FLD_W-1:0] FLD_MONTH = 2'd1;
  localparam logic [FLD_W-1:0] FLD_YEAR  = 2'd2;

  localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

  localparam logic [CNT_W-1:0] DM_MAX_DIGITS   = 3'd2;
  localparam logic [CNT_W-1:0] YEAR_MAX_DIGITS = 3'd4;
  localparam logic [CNT_W-1:0] YEAR_SHORT      = 3'd2;
  localparam logic [CNT_W-1:0] YEAR_LONG       = 3'd4;

  typedef struct packed {
    logic [FLD_W-1:0]  field_index;
    logic [CNT_W-1:0]  digit_count;
    logic [VAL_W-1:0]  day_value;
    logic [VAL_W-1:0]  month_value;
    logic [YDIG_W-1:0] year_digits;
    logic              format_error;
  } parse_t;

  typedef struct packed {
    logic               date_ok;
    logic [DAY_W-1:0]   day_out;
    logic [MONTH_W-1:0] month_out;
    logic [YEAR_W-1:0]  year_out;
  } result_t;

endpackage

// ===== sv/dsv_in_if.sv =====
// Character channel of the date string validator: valid, ready and payload.
// Depends on dsv_pkg.
interface dsv_in_if;
  import dsv_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] character;
  logic              is_last;

  modport source (output valid, character, is_last, input ready);
  modport sink (input valid, character, is_last, output ready);
endinterface

// ===== sv/dsv_out_if.sv =====
// Result channel of the date string validator: valid, ready and payload.
// Depends on dsv_pkg.
interface dsv_out_if;
  import dsv_pkg::*;

  logic               valid;
  logic               ready;
  logic               date_ok;
  logic [DAY_W-1:0]   day_out;
  logic [MONTH_W-1:0] month_out;
  logic [YEAR_W-1:0]  year_out;

  modport source (output valid, date_ok, day_out, month_out, year_out, input ready);
  modport sink (input valid, date_ok, day_out, month_out, year_out, output ready);
endinterface

// ===== sv/dsv_parser.sv =====
// Character parser: holds the field, digit count, day, month and year digits
// and the sticky format error. Depends on dsv_pkg.
module dsv_parser (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      step_i,
  input  logic                      last_i,
  input  logic [dsv_pkg::CHAR_W-1:0] char_i,
  output dsv_pkg::parse_t           snap_o
);
  import dsv_pkg::*;

  parse_t              st_q;
  parse_t              st_d;
  logic [DIGIT_W-1:0]  digit;
  logic [10:0]         acc;

  assign digit = DIGIT_W'(char_i - CH_ZERO);

  always_comb begin
    st_d = st_q;
    acc  = '0;
    if (char_i == CH_SLASH) begin
      if (st_q.field_index < FLD_YEAR) begin
        if (st_q.digit_count == '0) begin
          st_d.format_error = 1'b1;
        end
        st_d.field_index = st_q.field_index + 1'b1;
        st_d.digit_count = '0;
      end else begin
        st_d.format_error = 1'b1;
      end
    end else if (char_i inside {[CH_ZERO:CH_NINE]}) begin
      if (st_q.field_index < FLD_YEAR) begin
        if (st_q.digit_count >= DM_MAX_DIGITS) begin
          st_d.format_error = 1'b1;
        end else begin
          if (st_q.field_index == FLD_DAY) begin
            acc = 11'(st_q.day_value) * 11'd10 + 11'(digit);
            st_d.day_value = acc[VAL_W-1:0];
          end else begin
            acc = 11'(st_q.month_value) * 11'd10 + 11'(digit);
            st_d.month_value = acc[VAL_W-1:0];
          end
          st_d.digit_count = st_q.digit_count + 1'b1;
        end
      end else begin
        if (st_q.digit_count >= YEAR_MAX_DIGITS) begin
          st_d.format_error = 1'b1;
        end else begin
          st_d.year_digits = {st_q.year_digits[YDIG_W-DIGIT_W-1:0], digit};
          st_d.digit_count = st_q.digit_count + 1'b1;
        end
      end
    end else begin
      st_d.format_error = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else if (step_i) begin
      st_q <= last_i ? parse_t'('0) : st_d;
    end
  end

  assign snap_o = st_d;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && last_i |=> st_q.field_index == FLD_DAY && st_q.digit_count == '0
                         && !st_q.format_error)
    else $error("parser state not cleared after the last character");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_i |=> $stable(st_q))
    else $error("parser state changed without a transaction");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.field_index != 2'd3 && st_q.digit_count <= YEAR_MAX_DIGITS)
    else $error("parser field or digit count out of range");

endmodule

// ===== sv/dsv_checker.sv =====
// Date check: builds the four-digit year and tests the month range and the
// month length with the Gregorian leap rule. Depends on dsv_pkg.
module dsv_checker (
  input  dsv_pkg::parse_t  snap_i,
  output dsv_pkg::result_t res_o
);
  import dsv_pkg::*;

  logic [DIGIT_W-1:0] n0, n1, n2, n3;
  logic               fmt_ok;
  logic [VAL_W-1:0]   cent;
  logic [VAL_W-1:0]   low2;
  logic [YEAR_W-1:0]  year;
  logic               leap;
  logic [DAY_W-1:0]   mlen;
  logic               month_ok;
  logic               day_ok;
  logic               ok;

  assign n0 = snap_i.year_digits[3:0];
  assign n1 = snap_i.year_digits[7:4];
  assign n2 = snap_i.year_digits[11:8];
  assign n3 = snap_i.year_digits[15:12];

  assign fmt_ok = !snap_i.format_error && snap_i.field_index == FLD_YEAR
                  && (snap_i.digit_count == YEAR_SHORT || snap_i.digit_count == YEAR_LONG);

  always_comb begin
    if (snap_i.digit_count == YEAR_SHORT) begin
      cent = (n1 > 4'd2 && n0 > 4'd4) ? 7'd19 : 7'd20;
    end else begin
      cent = VAL_W'(n3) * 7'd10 + VAL_W'(n2);
    end
  end

  assign low2 = VAL_W'(n1) * 7'd10 + VAL_W'(n0);
  assign year = YEAR_W'(cent) * 14'd100 + YEAR_W'(low2);
  assign leap = (low2 != '0 && low2[1:0] == 2'b00)
                || (low2 == '0 && cent[1:0] == 2'b00);

  assign month_ok = snap_i.month_value >= 7'd1 && snap_i.month_value <= 7'd12;

  always_comb begin
    case (snap_i.month_value[MONTH_W-1:0])
      4'd4, 4'd6, 4'd9, 4'd11: mlen = 5'd30;
      4'd2:                    mlen = leap ? 5'd29 : 5'd28;
      default:                 mlen = 5'd31;
    endcase
  end

  assign day_ok = snap_i.day_value >= 7'd1 && snap_i.day_value <= VAL_W'(mlen);
  assign ok     = fmt_ok && month_ok && day_ok;

  always_comb begin
    res_o = '0;
    if (ok) begin
      res_o.date_ok   = 1'b1;
      res_o.day_out   = snap_i.day_value[DAY_W-1:0];
      res_o.month_out = snap_i.month_value[MONTH_W-1:0];
      res_o.year_out  = year;
    end
  end

endmodule

// ===== sv/date_string_validator_top.sv =====
// Date string validator, top level: input register, parser, date check and
// result register. Depends on dsv_pkg, dsv_in_if, dsv_out_if, dsv_parser, dsv_checker.
// The result of a character marked last passes the input register and is then held in the result register.
// Throughput: one character per cycle; the input register and the result register
// decouple the two channels, so a stalled result only blocks a following last character.
// Reset clears the parser state and both valid flags; the block accepts at once.
module date_string_validator_top (
  input  logic      clk_i,
  input  logic      rst_ni,
  dsv_in_if.sink    src_i,
  dsv_out_if.source res_o
);
  import dsv_pkg::*;

  logic              a_valid_q;
  logic [CHAR_W-1:0] a_char_q;
  logic              a_last_q;
  logic              out_free;
  logic              step;
  logic              o_valid_q;
  result_t           o_res_q;
  parse_t            snap;
  result_t           res;

  assign out_free    = !o_valid_q || res_o.ready;
  assign step        = a_valid_q && (!a_last_q || out_free);
  assign src_i.ready = !a_valid_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (src_i.ready) begin
      a_valid_q <= src_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (src_i.ready && src_i.valid) begin
      a_char_q <= src_i.character;
      a_last_q <= src_i.is_last;
    end
  end

  dsv_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .last_i (a_last_q),
    .char_i (a_char_q),
    .snap_o (snap)
  );

  dsv_checker u_checker (
    .snap_i (snap),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_valid_q <= 1'b0;
    end else if (step && a_last_q) begin
      o_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      o_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && a_last_q) begin
      o_res_q <= res;
    end
  end

  assign res_o.valid     = o_valid_q;
  assign res_o.date_ok   = o_res_q.date_ok;
  assign res_o.day_out   = o_res_q.day_out;
  assign res_o.month_out = o_res_q.month_out;
  assign res_o.year_out  = o_res_q.year_out;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && !res_o.date_ok |-> res_o.day_out == '0 && res_o.month_out == '0
                                      && res_o.year_out == '0)
    else $error("invalid date transaction carries nonzero fields");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.date_ok |-> res_o.month_out >= 4'd1 && res_o.month_out <= 4'd12
                                     && res_o.day_out != '0)
    else $error("valid date transaction with month or day out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !src_i.ready |-> a_valid_q && a_last_q && o_valid_q && !res_o.ready)
    else $error("input stalled without a blocked last character");

endmodule
